FILE: src/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; the using module provides clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every rising edge outside reset
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

FILE: src/rsx_pkg.sv
// types and constants for the risc subset executor
// no dependencies
package rsx_pkg;

    localparam int unsigned XLEN       = 32;
    localparam int unsigned REG_COUNT  = 32;
    localparam int unsigned REG_IDX_W  = 5;
    localparam int unsigned PWORDS_W   = 30;
    localparam int unsigned PC_STEP    = 4;

    // primary opcodes
    typedef enum logic [5:0] {
        OP_SPECIAL = 6'b000000,
        OP_BEQ     = 6'b000100,
        OP_BNE     = 6'b000101,
        OP_ADDI    = 6'b001000
    } opcode_t;

    // function codes of the special group
    typedef enum logic [5:0] {
        FN_SLL = 6'b000000,
        FN_SRL = 6'b000010,
        FN_SRA = 6'b000011,
        FN_ADD = 6'b100000,
        FN_AND = 6'b100100,
        FN_OR  = 6'b100101,
        FN_SLT = 6'b101010
    } funct_t;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [XLEN-1:0]      word_t;

    // one result item
    typedef struct packed {
        word_t    pc_after;
        logic     reg_written;
        reg_idx_t dest_index;
        word_t    write_value;
        logic     unknown_instruction;
        logic     past_end;
    } result_t;

    // sign-extend a 16-bit immediate to a full word
    function automatic word_t sext16(input logic [15:0] imm);
        return {{(XLEN-16){imm[15]}}, imm};
    endfunction

endpackage

FILE: src/rsx_instr_if.sv
// instruction channel: valid/ready handshake with one instruction word
// depends on rsx_pkg
interface rsx_instr_if import rsx_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

FILE: src/rsx_result_if.sv
// result channel: valid/ready handshake with the fields of one result item
// depends on rsx_pkg
interface rsx_result_if import rsx_pkg::*; ();
    logic     valid;
    logic     ready;
    word_t    pc_after;
    logic     reg_written;
    reg_idx_t dest_index;
    word_t    write_value;
    logic     unknown_instruction;
    logic     past_end;

    modport source (
        output valid, output pc_after, output reg_written, output dest_index,
        output write_value, output unknown_instruction, output past_end,
        input ready
    );
    modport sink (
        input valid, input pc_after, input reg_written, input dest_index,
        input write_value, input unknown_instruction, input past_end,
        output ready
    );
endinterface

FILE: src/risc_instruction_subset_executor.sv
// top level: executes one instruction item per cycle while the result is not stalled, against a 32-entry register file
// depends on rsx_pkg, rsx_instr_if, rsx_result_if and assert_macros.svh
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+------------------------------------------
//  instr     | in  | valid / ready    | instruction_word[31:0]
//  result    | out | valid / ready    | pc_after, reg_written, dest_index,
//            |     |                  | write_value, unknown_instruction, past_end
//  cfg       | in  | cfg_wr_en        | cfg_wr_data[29:0] (program_words)
//
//  one item per cycle sustained while the result is not stalled; a taken item passes the
//  input and register file read registers, then is executed into the result register
//  the register file is read at its registered read port; a write from the item in
//  execute during the same edge is bypassed into the operand
//  reset clears pc, program_words and the register file valid bits; no clearing pass
//  a stalled result holds the item in the input register, which drops instr ready
`include "assert_macros.svh"

module risc_instruction_subset_executor
    import rsx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [PWORDS_W-1:0] cfg_wr_data,
    rsx_instr_if.sink           instr,
    rsx_result_if.source        result
);

    // register file storage, valid bits and read registers
    word_t                mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    word_t                rd_s_reg;
    word_t                rd_t_reg;

    // operand bypass from the executing item
    logic  byp_s_reg;
    logic  byp_t_reg;
    word_t byp_val_reg;

    // input stage
    logic  ir_valid_reg;
    word_t ir_reg;

    // architectural state
    word_t               pc_reg;
    logic [PWORDS_W-1:0] pwords_reg;

    // result register
    logic    out_valid_reg;
    result_t out_reg;
    result_t out_next;

    logic     accept;
    logic     exec_fire;
    reg_idx_t rs_in;
    reg_idx_t rt_in;

    logic [5:0] opcode;
    logic [5:0] funct;
    reg_idx_t   rs;
    reg_idx_t   rt;
    reg_idx_t   rd;
    logic [4:0] sa;
    word_t      vs;
    word_t      vt;
    word_t      imm_ext;
    word_t      next_pc;
    logic       writes;
    logic       unknown;
    reg_idx_t   dest;
    word_t      val;
    logic       wr_en;

    // handshake
    assign exec_fire   = ir_valid_reg && (!out_valid_reg || result.ready);
    assign accept      = instr.valid && instr.ready;
    assign instr.ready = !ir_valid_reg || exec_fire;
    assign rs_in       = instr.instruction_word[25:21];
    assign rt_in       = instr.instruction_word[20:16];

    // field split of the held instruction
    assign opcode  = ir_reg[31:26];
    assign rs      = ir_reg[25:21];
    assign rt      = ir_reg[20:16];
    assign rd      = ir_reg[15:11];
    assign sa      = ir_reg[10:6];
    assign funct   = ir_reg[5:0];
    assign imm_ext = sext16(ir_reg[15:0]);

    // operand select: bypass, then stored entry, else reset value
    always_comb
    begin
        if (byp_s_reg)
            vs = byp_val_reg;
        else if (valid_reg[rs])
            vs = rd_s_reg;
        else
            vs = '0;
        if (byp_t_reg)
            vt = byp_val_reg;
        else if (valid_reg[rt])
            vt = rd_t_reg;
        else
            vt = '0;
    end

    // execute
    always_comb
    begin
        next_pc = pc_reg + XLEN'(PC_STEP);
        writes  = 1'b0;
        unknown = 1'b0;
        dest    = '0;
        val     = '0;
        case (opcode)
            OP_ADDI:
            begin
                writes = 1'b1;
                dest   = rt;
                val    = vs + imm_ext;
            end
            OP_BEQ, OP_BNE:
            begin
                if ((opcode == OP_BEQ) == (vs == vt))
                    next_pc = pc_reg + XLEN'(PC_STEP) + {imm_ext[XLEN-3:0], 2'b00};
            end
            OP_SPECIAL:
            begin
                writes = 1'b1;
                dest   = rd;
                case (funct)
                    FN_ADD: val = vs + vt;
                    FN_AND: val = vs & vt;
                    FN_OR:  val = vs | vt;
                    FN_SLT: val = XLEN'($signed(vs) < $signed(vt));
                    FN_SLL: val = vt << sa;
                    FN_SRL: val = vt >> sa;
                    FN_SRA: val = word_t'($signed(vt) >>> sa);
                    default:
                    begin
                        writes  = 1'b0;
                        unknown = 1'b1;
                        dest    = '0;
                    end
                endcase
            end
            default: unknown = 1'b1;
        endcase
        wr_en = writes && (dest != '0);

        out_next.pc_after            = next_pc;
        out_next.reg_written         = wr_en;
        out_next.dest_index          = wr_en ? dest : '0;
        out_next.write_value         = wr_en ? val : '0;
        out_next.unknown_instruction = unknown;
        out_next.past_end            = next_pc >= {pwords_reg, 2'b00};
    end

    // register file write and registered read ports
    always_ff @(posedge clk)
    begin
        if (exec_fire && wr_en)
            mem[dest] <= val;
        if (accept)
        begin
            rd_s_reg <= mem[rs_in];
            rd_t_reg <= mem[rt_in];
        end
    end

    // bypass capture, input stage payload and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ir_reg      <= instr.instruction_word;
            byp_val_reg <= val;
        end
        if (exec_fire)
            out_reg <= out_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            byp_s_reg     <= 1'b0;
            byp_t_reg     <= 1'b0;
            ir_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            pwords_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                pwords_reg <= cfg_wr_data;
            if (accept)
            begin
                byp_s_reg <= exec_fire && wr_en && (dest == rs_in);
                byp_t_reg <= exec_fire && wr_en && (dest == rt_in);
            end
            if (exec_fire)
            begin
                pc_reg <= next_pc;
                if (wr_en)
                    valid_reg[dest] <= 1'b1;
            end
            if (accept)
                ir_valid_reg <= 1'b1;
            else if (exec_fire)
                ir_valid_reg <= 1'b0;
            if (exec_fire)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result channel
    assign result.valid               = out_valid_reg;
    assign result.pc_after            = out_reg.pc_after;
    assign result.reg_written         = out_reg.reg_written;
    assign result.dest_index          = out_reg.dest_index;
    assign result.write_value         = out_reg.write_value;
    assign result.unknown_instruction = out_reg.unknown_instruction;
    assign result.past_end            = out_reg.past_end;

    // checks
    `ASSERT_CLK(a_r0_never_valid, !valid_reg[0], "register zero marked as written")
    `ASSERT_IMPLY(a_out_from_exec, $rose(out_valid_reg), $past(exec_fire), "result without execute")
    `ASSERT_IMPLY(a_write_nonzero, out_valid_reg && out_reg.reg_written, out_reg.dest_index != '0, "write reported to register zero")
    `ASSERT_IMPLY(a_unknown_no_write, out_valid_reg && out_reg.unknown_instruction, !out_reg.reg_written, "unknown item wrote a register")
    `ASSERT_IMPLY(a_pc_advances, exec_fire, ##1 (pc_reg == $past(next_pc)), "pc not updated by execute")

endmodule
